// ===== src/rscs_pkg.sv =====
// ---------------------------------------------------------------------------
// rscs_pkg
// shared types and constants of the record stream chunk segmenter
// ---------------------------------------------------------------------------
package rscs_pkg;

  // configuration register indexes
  localparam logic REG_MAX_RECORDS = 1'b0;
  localparam logic REG_MAX_BYTES   = 1'b1;

  localparam int RECS_W   = 16;   // max_records_per_chunk width
  localparam int BYTES_W  = 21;   // max_chunk_bytes width
  localparam int OFFS_W   = 32;   // record offset width
  localparam int SIZE_W   = 12;   // record size width
  localparam int IDX_W    = 16;   // record index width on the output

  // most chunks emitted for one record
  localparam int RESULT_LIMIT = 64;
  localparam int PIECE_W      = $clog2(RESULT_LIMIT);

  // classified record as it waits in the queue
  typedef struct packed {
    logic [OFFS_W-1:0] rec_end;
    logic              final_rec;
  } item_t;

  // one chunk word
  typedef struct packed {
    logic [IDX_W-1:0]   first_record;
    logic [IDX_W-1:0]   end_record;
    logic [OFFS_W-1:0]  chunk_byte_start;
    logic [BYTES_W-1:0] chunk_byte_length;
    logic               incomplete;
    logic               last_of_run;
  } chunk_t;

endpackage

// ===== src/record_stream_chunk_segmenter.sv =====
// ---------------------------------------------------------------------------
// record_stream_chunk_segmenter
// groups a stream of records into chunks bounded by record count and bytes
// ---------------------------------------------------------------------------
// usage:
//   s_* takes one record word per handshake: offset and size in s_tdata,
//   the last record of a collection flagged by s_tlast.
//   m_* gives chunk words: indexes, byte start and length in m_tdata,
//   the incomplete flag in m_tuser, m_tlast on the final chunk of a record.
//   cfg_we/cfg_addr/cfg_wdata write the two limits; write only while idle.
// throughput:
//   a record sits in a two-word queue from the edge that accepts it; the
//   sequencer makes one close decision per cycle while no pending chunk
//   waits on m_tready, so a record takes one decision when it makes at
//   most one chunk, and one decision per chunk when it is split (up to
//   64 chunks). the first chunk word is registered from the queue head.
//   the subtract/compare on the chunk span is combinational.
// reset:
//   clears the record index, chunk start and queue; limits return to
//   64 records and 1024 bytes.
// stall:
//   a low m_tready with a chunk pending stalls the sequencer at the next close; the queue
//   still takes up to two records before s_tready drops.
// ---------------------------------------------------------------------------
module record_stream_chunk_segmenter import rscs_pkg::*; #(
  parameter int MAX_RECORDS = 65536
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_we,
  input  logic               cfg_addr,
  input  logic [BYTES_W-1:0] cfg_wdata,
  // record input
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [47:0]        s_tdata,   // record_offset[31:0], record_size[43:32], zero pad
  input  logic               s_tlast,   // final_record
  // chunk output
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [87:0]        m_tdata,   // first_record[15:0], end_record[31:16],
                                        // chunk_byte_start[63:32],
                                        // chunk_byte_length[84:64], zero pad
  output logic               m_tuser,   // incomplete
  output logic               m_tlast    // last_of_run
);

  logic [RECS_W-1:0]  max_records;
  logic [BYTES_W-1:0] max_bytes;

  logic   q_valid;
  logic   q_pop;
  item_t  q_item;
  chunk_t chunk;

  // limit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_records <= RECS_W'(64);
      max_bytes   <= BYTES_W'(1024);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MAX_RECORDS: max_records <= cfg_wdata[RECS_W-1:0];
        REG_MAX_BYTES:   max_bytes   <= cfg_wdata;
        default:         max_bytes   <= max_bytes;
      endcase
    end
  end

  // front: accept and queue records
  rscs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_offset (s_tdata[31:0]),
    .in_size   (s_tdata[43:32]),
    .in_final  (s_tlast),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item)
  );

  // back: close decisions and chunk words
  rscs_back #(
    .MAX_RECORDS (MAX_RECORDS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .max_records (max_records),
    .max_bytes   (max_bytes),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_chunk   (chunk)
  );

  // pack the chunk word, first field in the low bits
  assign m_tdata = {3'b000, chunk.chunk_byte_length, chunk.chunk_byte_start,
                    chunk.end_record, chunk.first_record};
  assign m_tuser = chunk.incomplete;
  assign m_tlast = chunk.last_of_run;

endmodule

// ===== src/rscs_front.sv =====
// ---------------------------------------------------------------------------
// rscs_front
// accepts record words, forms the record end byte and queues them
// ---------------------------------------------------------------------------
module rscs_front import rscs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OFFS_W-1:0] in_offset,
  input  logic [SIZE_W-1:0] in_size,
  input  logic              in_final,
  output logic              q_valid,
  input  logic              q_pop,
  output item_t             q_item
);

  item_t [1:0] slot;
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  fill;
  logic        push;
  item_t       new_item;

  assign in_ready = (fill != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (fill != 2'd0);
  assign q_item   = slot[rd_ptr];

  // end byte wraps modulo 2^32
  always_comb begin
    new_item.rec_end   = in_offset + {{(OFFS_W-SIZE_W){1'b0}}, in_size};
    new_item.final_rec = in_final;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, q_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== src/rscs_back.sv =====
// ---------------------------------------------------------------------------
// rscs_back
// chunk sequencer: unless stalled, a close decision and chunk word per cycle
// ---------------------------------------------------------------------------
module rscs_back import rscs_pkg::*; #(
  parameter int MAX_RECORDS = 65536
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [RECS_W-1:0]  max_records,
  input  logic [BYTES_W-1:0] max_bytes,
  input  logic               q_valid,
  input  item_t              q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output chunk_t             out_chunk
);

  localparam int IW = (MAX_RECORDS > 2) ? $clog2(MAX_RECORDS) : 1;
  localparam int CW = IW + 1;
  localparam int EW = (CW > IDX_W) ? CW : IDX_W;

  logic [IW-1:0]      rc;
  logic [IW-1:0]      cfi;
  logic [OFFS_W-1:0]  csb;
  logic [PIECE_W-1:0] pc;

  logic [BYTES_W-1:0] limit;
  logic [CW-1:0]      diff;
  logic [CW-1:0]      wrapped;
  logic [CW-1:0]      count;
  logic [EW-1:0]      count_ext;
  logic [EW-1:0]      cfi_ext;
  logic [EW-1:0]      end_ext;
  logic [IW-1:0]      rc_inc;
  logic [OFFS_W-1:0]  span;
  logic [OFFS_W-1:0]  limit_ext;
  logic               close;
  logic               inc;
  logic               more;
  logic [BYTES_W-1:0] piece;
  logic               step;

  always_comb begin
    limit     = (max_bytes == '0) ? BYTES_W'(1) : max_bytes;
    limit_ext = {{(OFFS_W-BYTES_W){1'b0}}, limit};
    // records in the open chunk including this one, index space wraps
    diff      = {1'b0, rc} - {1'b0, cfi};
    wrapped   = diff[IW] ? diff + CW'(MAX_RECORDS) : diff;
    count     = wrapped + CW'(1);
    count_ext = EW'(count);
    cfi_ext   = EW'(cfi);
    end_ext   = cfi_ext + count_ext;
    rc_inc    = (rc == IW'(MAX_RECORDS - 1)) ? '0 : rc + IW'(1);
    span      = q_item.rec_end - csb;
    close     = (count_ext[IDX_W-1:0] == max_records) || (span >= limit_ext)
                || q_item.final_rec;
    inc       = span > limit_ext;
    piece     = inc ? limit : span[BYTES_W-1:0];
    more      = inc && (pc != PIECE_W'(RESULT_LIMIT - 1));
    step      = q_valid && (!close || !out_valid || out_ready);
    q_pop     = step && (!close || !more);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rc  <= '0;
      cfi <= '0;
      csb <= '0;
      pc  <= '0;
    end else if (step) begin
      if (!close) begin
        rc <= rc_inc;
        pc <= '0;
      end else if (more) begin
        cfi <= rc;
        csb <= csb + {{(OFFS_W-BYTES_W){1'b0}}, piece};
        pc  <= pc + PIECE_W'(1);
      end else if (q_item.final_rec) begin
        rc  <= '0;
        cfi <= '0;
        csb <= '0;
        pc  <= '0;
      end else begin
        rc  <= rc_inc;
        cfi <= rc_inc;
        csb <= csb + {{(OFFS_W-BYTES_W){1'b0}}, piece};
        pc  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && close) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && close) begin
      out_chunk.first_record      <= cfi_ext[IDX_W-1:0];
      out_chunk.end_record        <= end_ext[IDX_W-1:0];
      out_chunk.chunk_byte_start  <= csb;
      out_chunk.chunk_byte_length <= piece;
      out_chunk.incomplete        <= inc;
      out_chunk.last_of_run       <= !more;
    end
  end

endmodule
